// File: rtl/ppb_pkg.sv
// ppb_pkg: types, constants and helper functions for the particle plane bounce pipeline.
// Used by ppb_bounce and particle_plane_bounce_step; depends on nothing else.
package ppb_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int COEF_BITS     = 17;
  localparam int SLAB_BITS     = 31;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRAVITY     = 3'd0,
    CFG_RESTITUTION = 3'd1,
    CFG_REST_SQ     = 3'd2,
    CFG_LIMIT_1     = 3'd3,
    CFG_LIMIT_2     = 3'd4,
    CFG_SLAB_1      = 3'd5,
    CFG_SLAB_2      = 3'd6
  } cfg_idx_t;

  localparam logic [COEF_BITS-1:0]        GRAVITY_RST     = 17'd6554;
  localparam logic [COEF_BITS-1:0]        RESTITUTION_RST = 17'd45875;
  localparam logic [COEF_BITS-1:0]        REST_SQ_RST     = 17'd655;
  localparam logic signed [WORD_BITS-1:0] LIMIT_1_RST     = -32'sd6553600;
  localparam logic signed [WORD_BITS-1:0] LIMIT_2_RST     = -32'sd9830400;
  localparam logic [SLAB_BITS-1:0]        SLAB_1_RST      = 31'd196608;
  localparam logic [SLAB_BITS-1:0]        SLAB_2_RST      = 31'd851968;

  // |t| of a dot product with (+-1,5,1) is at most 7*2^31
  localparam int TMAG_BITS   = 34;
  // floor(2^34 / 27); the estimate is low by at most one
  localparam int RECIP_BITS  = 30;
  localparam logic [RECIP_BITS-1:0] RECIP_27 = 30'd636291451;
  localparam int DOT_BITS    = 36;
  localparam int SAT_IN_BITS = 36;

  // stages inside one bounce unit, output register included
  localparam int BNC_LAT = 14;

  localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] pos_z;
    logic signed [WORD_BITS-1:0] vel_x;
    logic signed [WORD_BITS-1:0] vel_y;
    logic signed [WORD_BITS-1:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] new_pos_x;
    logic signed [WORD_BITS-1:0] new_pos_y;
    logic signed [WORD_BITS-1:0] new_pos_z;
    logic signed [WORD_BITS-1:0] new_vel_x;
    logic signed [WORD_BITS-1:0] new_vel_y;
    logic signed [WORD_BITS-1:0] new_vel_z;
    logic [1:0]                  hit_mask;
  } out_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] x;
    logic signed [WORD_BITS-1:0] y;
    logic signed [WORD_BITS-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } bnc_ctl_t;

  typedef struct packed {
    logic [1:0] hits;
    vec3_t      pos;
  } dly_t;

  function automatic logic signed [WORD_BITS-1:0] sat_w(
    input logic signed [SAT_IN_BITS-1:0] v
  );
    logic [SAT_IN_BITS-WORD_BITS:0] top;
    top = v[SAT_IN_BITS-1:WORD_BITS-1];
    if (&top || ~|top) return v[WORD_BITS-1:0];
    return v[SAT_IN_BITS-1] ? W_MIN : W_MAX;
  endfunction

  // floor((2*d*rem + 13) / 27) for rem < 27, d = 5 when five else 1
  function automatic logic [3:0] rnd_corr(input logic [4:0] rem, input logic five);
    logic [8:0] num;
    logic [3:0] q;
    num = five ? (9'(rem) * 9'd10 + 9'd13) : ({3'b000, rem, 1'b0} + 9'd13);
    q = '0;
    for (int k = 1; k <= 10; k++) begin
      if (num >= 9'(27 * k)) q = 4'(k);
    end
    return q;
  endfunction

endpackage

// File: rtl/ppb_bounce.sv
// ppb_bounce: one plane reflection with restitution and rest test, 14-stage pipeline.
// Depends on ppb_pkg; instantiated twice by particle_plane_bounce_step.
module ppb_bounce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       dir_neg,
  input  logic [16:0]                restitution,
  input  logic [16:0]                rest_sq,
  input  ppb_pkg::bnc_ctl_t          in_ctl,
  input  ppb_pkg::vec3_t             in_vel,
  output logic                       out_valid,
  output ppb_pkg::vec3_t             out_vel
);
  import ppb_pkg::*;

  localparam int STG = BNC_LAT - 1;

  logic [BNC_LAT-1:0]          vld_r;
  logic [STG-1:0]              hit_r;
  logic signed [WORD_BITS-1:0] vin [3];
  logic signed [WORD_BITS-1:0] vorig_r [STG][3];

  logic signed [DOT_BITS-1:0]  t_nxt, t1_r;
  logic [TMAG_BITS-1:0]        tm2_r, tm3_r;
  logic                        tneg2_r, tneg3_r, tneg4_r, tneg5_r, tneg6_r;
  logic [TMAG_BITS+RECIP_BITS-1:0] prod3;
  logic [RECIP_BITS-1:0]       q3_r, q4_r, q5_r;
  logic [TMAG_BITS:0]          rem_wide;
  logic [5:0]                  rem4_r;
  logic [4:0]                  r5_r;
  logic [RECIP_BITS:0]         c1_r;
  logic [TMAG_BITS-1:0]        c5_r;

  logic signed [TMAG_BITS:0]   a7_r [3];
  logic [TMAG_BITS-1:0]        am8_r [3];
  logic [2:0]                  aneg8_r, aneg9_r, aneg10_r;
  logic [TMAG_BITS+16:0]       pr9_r [3];
  logic [TMAG_BITS:0]          qq10_r [3];
  logic signed [WORD_BITS-1:0] r11_r [3], r12_r [3], r13_r [3];
  logic [23:0]                 rm12_r [3];
  logic                        big12_r, big13_r;
  logic [47:0]                 sq13_r [3];
  logic [49:0]                 sq_sum;
  logic                        below;
  logic signed [WORD_BITS-1:0] vout_r [3];

  assign vin[0] = in_vel.x;
  assign vin[1] = in_vel.y;
  assign vin[2] = in_vel.z;

  assign t_nxt = (dir_neg ? -DOT_BITS'(in_vel.x) : DOT_BITS'(in_vel.x))
               + (DOT_BITS'(in_vel.y) <<< 2) + DOT_BITS'(in_vel.y)
               + DOT_BITS'(in_vel.z);
  assign prod3    = (TMAG_BITS+RECIP_BITS)'(tm2_r) * (TMAG_BITS+RECIP_BITS)'(RECIP_27);
  assign rem_wide = (TMAG_BITS+1)'(tm3_r) - (TMAG_BITS+1)'(q3_r) * (TMAG_BITS+1)'(27);
  assign sq_sum   = 50'(sq13_r[0]) + 50'(sq13_r[1]) + 50'(sq13_r[2]);
  assign below    = !big13_r && (sq_sum < 50'({rest_sq, {FRAC_BITS{1'b0}}}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[BNC_LAT-2:0], in_ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= {hit_r[STG-2:0], in_ctl.hit};
      for (int i = 0; i < 3; i++) vorig_r[0][i] <= vin[i];
      for (int s = 1; s < STG; s++) vorig_r[s] <= vorig_r[s-1];

      t1_r <= t_nxt;

      tm2_r   <= t1_r[DOT_BITS-1] ? TMAG_BITS'(-t1_r) : TMAG_BITS'(t1_r);
      tneg2_r <= t1_r[DOT_BITS-1];

      q3_r    <= prod3[TMAG_BITS+RECIP_BITS-1:TMAG_BITS];
      tm3_r   <= tm2_r;
      tneg3_r <= tneg2_r;

      q4_r    <= q3_r;
      rem4_r  <= rem_wide[5:0];
      tneg4_r <= tneg3_r;

      if (rem4_r >= 6'd27) begin
        q5_r <= q4_r + 1'b1;
        r5_r <= 5'(rem4_r - 6'd27);
      end else begin
        q5_r <= q4_r;
        r5_r <= rem4_r[4:0];
      end
      tneg5_r <= tneg4_r;

      c1_r    <= {q5_r, 1'b0} + (RECIP_BITS+1)'(rnd_corr(r5_r, 1'b0));
      c5_r    <= TMAG_BITS'(q5_r) * TMAG_BITS'(10) + TMAG_BITS'(rnd_corr(r5_r, 1'b1));
      tneg6_r <= tneg5_r;

      for (int i = 0; i < 3; i++) begin
        logic signed [TMAG_BITS:0] c;
        logic                      cneg;
        c    = (i == 1) ? $signed({1'b0, c5_r}) : $signed({4'b0000, c1_r});
        cneg = tneg6_r ^ ((i == 0) && dir_neg);
        a7_r[i] <= cneg ? ((TMAG_BITS+1)'(vorig_r[5][i]) + c)
                        : ((TMAG_BITS+1)'(vorig_r[5][i]) - c);

        am8_r[i]   <= a7_r[i][TMAG_BITS] ? TMAG_BITS'(-a7_r[i]) : TMAG_BITS'(a7_r[i]);
        aneg8_r[i] <= a7_r[i][TMAG_BITS];

        pr9_r[i]   <= (TMAG_BITS+17)'(am8_r[i]) * (TMAG_BITS+17)'(restitution);
        aneg9_r[i] <= aneg8_r[i];

        qq10_r[i]   <= (TMAG_BITS+1)'((pr9_r[i] + (TMAG_BITS+17)'(1 << (FRAC_BITS-1)))
                                      >> FRAC_BITS);
        aneg10_r[i] <= aneg9_r[i];

        r11_r[i] <= sat_w(aneg10_r[i] ? -$signed({1'b0, qq10_r[i]})
                                      : $signed({1'b0, qq10_r[i]}));
      end

      for (int i = 0; i < 3; i++) begin
        logic signed [WORD_BITS:0] m;
        m = r11_r[i][WORD_BITS-1] ? -(WORD_BITS+1)'(r11_r[i]) : (WORD_BITS+1)'(r11_r[i]);
        rm12_r[i] <= m[23:0];
        r12_r[i]  <= r11_r[i];
        sq13_r[i] <= 48'(rm12_r[i]) * 48'(rm12_r[i]);
        r13_r[i]  <= r12_r[i];
        vout_r[i] <= hit_r[STG-1] ? (below ? '0 : r13_r[i]) : vorig_r[STG-1][i];
      end
      big12_r <= |{((r11_r[0] >= 32'sd16777216) || (r11_r[0] <= -32'sd16777216)),
                   ((r11_r[1] >= 32'sd16777216) || (r11_r[1] <= -32'sd16777216)),
                   ((r11_r[2] >= 32'sd16777216) || (r11_r[2] <= -32'sd16777216))};
      big13_r <= big12_r;
    end
  end

  assign out_valid = vld_r[BNC_LAT-1];
  assign out_vel   = '{x: vout_r[0], y: vout_r[1], z: vout_r[2]};

`ifndef SYNTHESIS
  a_rem_est: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> rem4_r < 6'd54)
    else $error("reciprocal estimate off by more than one");
  a_rem_fix: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> r5_r < 5'd27)
    else $error("corrected remainder out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while held");
`endif

endmodule

// File: rtl/particle_plane_bounce_step.sv
// particle_plane_bounce_step: one frame of particle motion with two slanted bounce planes.
// Depends on ppb_pkg and ppb_bounce.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   input   | in_valid, in_stall, in_data         | in
//   result  | out_valid, out_stall, out_data      | out
//   config  | cfg_wr_en, cfg_index, cfg_wdata     | in
//
// One transfer per cycle unless the result is held; stages: advance, plane test, two bounce units.
// rst_n is synchronous: clears all valid bits and returns the config registers to their defaults.
// A held result (out_valid with out_stall) freezes the whole pipeline; in_stall rises
// in the same cycle. Nothing is dropped or repeated.
module particle_plane_bounce_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ppb_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ppb_pkg::out_item_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [ppb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ppb_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import ppb_pkg::*;

  localparam int DLY = 2 * BNC_LAT + 1;

  logic [COEF_BITS-1:0]        gravity_r, restitution_r, rest_sq_r;
  logic signed [WORD_BITS-1:0] limit1_r, limit2_r;
  logic [SLAB_BITS-1:0]        slab1_r, slab2_r;

  logic                        en;
  logic                        s1_vld_r, s2_vld_r;
  vec3_t                       s1_pos_r, s1_vel_r, s2_vel_r;
  vec3_t                       pos_nxt, vel_nxt;
  dly_t                        s2_nxt;
  dly_t                        dly_r [DLY];
  logic signed [DOT_BITS-1:0]  dot_common, dot1, dot2;
  logic signed [WORD_BITS:0]   x33, h1, h2;
  bnc_ctl_t                    b1_ctl, b2_ctl;
  logic                        b1_valid, b2_valid;
  vec3_t                       b1_vel, b2_vel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r     <= GRAVITY_RST;
      restitution_r <= RESTITUTION_RST;
      rest_sq_r     <= REST_SQ_RST;
      limit1_r      <= LIMIT_1_RST;
      limit2_r      <= LIMIT_2_RST;
      slab1_r       <= SLAB_1_RST;
      slab2_r       <= SLAB_2_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRAVITY:     gravity_r     <= cfg_wdata[COEF_BITS-1:0];
        CFG_RESTITUTION: restitution_r <= cfg_wdata[COEF_BITS-1:0];
        CFG_REST_SQ:     rest_sq_r     <= cfg_wdata[COEF_BITS-1:0];
        CFG_LIMIT_1:     limit1_r      <= cfg_wdata[WORD_BITS-1:0];
        CFG_LIMIT_2:     limit2_r      <= cfg_wdata[WORD_BITS-1:0];
        CFG_SLAB_1:      slab1_r       <= cfg_wdata[SLAB_BITS-1:0];
        CFG_SLAB_2:      slab2_r       <= cfg_wdata[SLAB_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: advance position, apply gravity
  assign pos_nxt.x = sat_w(SAT_IN_BITS'(in_data.pos_x) + SAT_IN_BITS'(in_data.vel_x));
  assign pos_nxt.y = sat_w(SAT_IN_BITS'(in_data.pos_y) + SAT_IN_BITS'(in_data.vel_y));
  assign pos_nxt.z = sat_w(SAT_IN_BITS'(in_data.pos_z) + SAT_IN_BITS'(in_data.vel_z));
  assign vel_nxt.x = in_data.vel_x;
  assign vel_nxt.y = sat_w(SAT_IN_BITS'(in_data.vel_y)
                         - $signed(SAT_IN_BITS'(gravity_r)));
  assign vel_nxt.z = in_data.vel_z;

  // stage 2: plane tests on the new position
  assign dot_common = (DOT_BITS'(s1_pos_r.y) <<< 2) + DOT_BITS'(s1_pos_r.y)
                    + DOT_BITS'(s1_pos_r.z);
  assign dot1 = dot_common + DOT_BITS'(s1_pos_r.x);
  assign dot2 = dot_common - DOT_BITS'(s1_pos_r.x);
  assign x33  = (WORD_BITS+1)'(s1_pos_r.x);
  assign h1   = $signed({2'b00, slab1_r});
  assign h2   = $signed({2'b00, slab2_r});

  assign s2_nxt.pos     = s1_pos_r;
  assign s2_nxt.hits[0] = (dot1 <= DOT_BITS'(limit1_r)) && (x33 <= h1) && (x33 >= -h1);
  assign s2_nxt.hits[1] = (dot2 <= DOT_BITS'(limit2_r)) && (x33 <= h2) && (x33 >= -h2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pos_r <= pos_nxt;
      s1_vel_r <= vel_nxt;
      s2_vel_r <= s1_vel_r;
      dly_r[0] <= s2_nxt;
      for (int s = 1; s < DLY; s++) dly_r[s] <= dly_r[s-1];
    end
  end

  // bounce units see the hit flag in step with their own input
  assign b1_ctl.valid = s2_vld_r;
  assign b1_ctl.hit   = dly_r[0].hits[0];
  assign b2_ctl.valid = b1_valid;
  assign b2_ctl.hit   = dly_r[BNC_LAT].hits[1];

  ppb_bounce u_bounce1 (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .dir_neg     (1'b0),
    .restitution (restitution_r),
    .rest_sq     (rest_sq_r),
    .in_ctl      (b1_ctl),
    .in_vel      (s2_vel_r),
    .out_valid   (b1_valid),
    .out_vel     (b1_vel)
  );

  ppb_bounce u_bounce2 (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .dir_neg     (1'b1),
    .restitution (restitution_r),
    .rest_sq     (rest_sq_r),
    .in_ctl      (b2_ctl),
    .in_vel      (b1_vel),
    .out_valid   (b2_valid),
    .out_vel     (b2_vel)
  );

  assign out_valid          = b2_valid;
  assign out_data.new_pos_x = dly_r[DLY-1].pos.x;
  assign out_data.new_pos_y = dly_r[DLY-1].pos.y;
  assign out_data.new_pos_z = dly_r[DLY-1].pos.z;
  assign out_data.new_vel_x = b2_vel.x;
  assign out_data.new_vel_y = b2_vel.y;
  assign out_data.new_vel_z = b2_vel.z;
  assign out_data.hit_mask  = dly_r[DLY-1].hits;

`ifndef SYNTHESIS
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !s1_vld_r && !s2_vld_r)
    else $error("valid bits survive reset");
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_vld_r)
    else $error("accepted transfer missing from stage 1");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s1_vld_r) && $stable(s2_vld_r) && $stable(b1_valid))
    else $error("front stages moved under stall");
`endif

endmodule
